// ===== design/potential_field_path_stepper_defines.svh =====
// assertion macros shared by the potential field path stepper
`ifndef POTENTIAL_FIELD_PATH_STEPPER_DEFINES_SVH
`define POTENTIAL_FIELD_PATH_STEPPER_DEFINES_SVH

// same-cycle implication under reset
`define PFPS_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define PFPS_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pfps_pkg.sv =====
// types, constants and helpers of the potential field path stepper
package pfps_pkg;

	localparam int COORD_W = 18;
	localparam int DIFF_W = COORD_W + 1;
	localparam int LEN_W = 17;
	localparam int GAIN_W = 8;
	localparam int CNT_W = 14;
	localparam int OP_W = 2;
	localparam int SLOT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_OBSTACLES = 16;
	localparam int OBS_IW = (NUM_OBSTACLES > 1) ? $clog2(NUM_OBSTACLES) : 1;

	// movement sum: attraction plus a repulsion and a swirl term per obstacle, q.16
	localparam int MOV_W = 28;
	localparam int MUL_W = MOV_W + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DSQ_W = 2 * DIFF_W;
	localparam int SQ_W = 2 * MOV_W;
	localparam int RT_W = SQ_W / 2;
	localparam int SQ_CW = $clog2(RT_W);
	localparam int DVD_W = PROD_W - 1;
	localparam int DVS_W = 2 * LEN_W;
	localparam int DIV_NW = DVD_W - 1;
	localparam int DIV_CW = $clog2(DIV_NW);
	localparam int QUO_W = MOV_W + 1;
	localparam int FRAC_SH = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [LEN_W-1:0] STEP_RST = LEN_W'(1600);
	localparam logic [LEN_W-1:0] UNIT_RST = LEN_W'(4800);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(20);
	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(9999);

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INFLUENCE_UNIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTRACTION_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAYPOINTS = 2'd3;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STEP = 2'd2;

	typedef struct packed {
		logic start;
		logic signed [DVD_W-1:0] dvd;
		logic [DVS_W-1:0] dvs;
	} div_req_t;

	typedef struct packed {
		logic start;
		logic [SQ_W-1:0] rad;
	} sqrt_req_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_G1, ST_G2, ST_G3, ST_G4, ST_DG,
		ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6,
		ST_OCHK,
		ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6, ST_O7, ST_O8, ST_O9,
		ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6,
		ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7, ST_T8,
		ST_ONEXT,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
		ST_FIN, ST_OUT
	} state_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] hi;
		logic signed [DIFF_W-1:0] lo;
		hi = DIFF_W'((1 <<< (COORD_W - 1)) - 1);
		lo = -DIFF_W'(1 <<< (COORD_W - 1));
		if (v > hi) begin
			return COORD_W'(hi);
		end else if (v < lo) begin
			return COORD_W'(lo);
		end
		return COORD_W'(v);
	endfunction

endpackage

// ===== design/pfps_divider.sv =====
// shared restoring divider, one quotient bit per cycle, rounds halves away from zero
module pfps_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfps_pkg::div_req_t                  req,
	output logic                                done,
	output logic signed [pfps_pkg::QUO_W-1:0]   quo
);

	logic [pfps_pkg::DIV_NW-1:0] num_q;
	logic [pfps_pkg::DVS_W-1:0] rem_q;
	logic [pfps_pkg::DVS_W-1:0] dvs_q;
	logic neg_q;
	logic run_q;
	logic done_q;
	logic [pfps_pkg::DIV_CW-1:0] cnt_q;

	logic [pfps_pkg::DVD_W-1:0] abs_v;
	logic [pfps_pkg::DIV_NW-1:0] mag;
	logic [pfps_pkg::DVS_W:0] trial;
	logic [pfps_pkg::DVS_W:0] diff;
	logic ge;
	logic signed [pfps_pkg::QUO_W-1:0] qmag;

	assign abs_v = req.dvd[pfps_pkg::DVD_W-1] ? pfps_pkg::DVD_W'(-req.dvd) : pfps_pkg::DVD_W'(req.dvd);
	// bias by half the divisor so truncation rounds to nearest
	assign mag = pfps_pkg::DIV_NW'(abs_v) + pfps_pkg::DIV_NW'(req.dvs >> 1);
	assign trial = {rem_q, num_q[pfps_pkg::DIV_NW-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = trial >= {1'b0, dvs_q};
	assign qmag = $signed(num_q[pfps_pkg::QUO_W-1:0]);
	assign quo = neg_q ? -qmag : qmag;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pfps_pkg::DIV_CW'(pfps_pkg::DIV_NW - 1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag;
			rem_q <= '0;
			dvs_q <= req.dvs;
			neg_q <= req.dvd[pfps_pkg::DVD_W-1];
		end else if (run_q) begin
			rem_q <= ge ? diff[pfps_pkg::DVS_W-1:0] : trial[pfps_pkg::DVS_W-1:0];
			num_q <= {num_q[pfps_pkg::DIV_NW-2:0], ge};
		end
	end

endmodule

// ===== design/pfps_isqrt.sv =====
// shared integer square root, one root bit per cycle, floor result
module pfps_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfps_pkg::sqrt_req_t           req,
	output logic                          done,
	output logic [pfps_pkg::RT_W-1:0]     root
);

	logic [pfps_pkg::SQ_W-1:0] rad_q;
	logic [pfps_pkg::RT_W+1:0] rem_q;
	logic [pfps_pkg::RT_W-1:0] root_q;
	logic [pfps_pkg::SQ_CW-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [pfps_pkg::RT_W+1:0] rem_sh;
	logic [pfps_pkg::RT_W+1:0] trial;
	logic ge;

	assign rem_sh = {rem_q[pfps_pkg::RT_W-1:0], rad_q[pfps_pkg::SQ_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge = rem_sh >= trial;
	assign root = root_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pfps_pkg::SQ_CW'(pfps_pkg::RT_W - 1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q <= req.rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[pfps_pkg::RT_W-2:0], ge};
		end
	end

endmodule

// ===== design/potential_field_path_stepper.sv =====
// Potential field path stepper. Load items fill a 16 entry obstacle table, a start item sets
// position and goal and returns waypoint 0, each step item on an active path returns the next
// waypoint one step length along attraction plus obstacle repulsion and swirl. All arithmetic
// runs on one registered 29x29 multiplier, one bit-serial divider and one bit-serial square
// root under a sequencer, and in_stall stays high until the result has been transferred. A
// load is taken without leaving the idle state, and a step spends almost all of its time in
// the divider.
`include "potential_field_path_stepper_defines.svh"

module potential_field_path_stepper (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pfps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pfps_pkg::LEN_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [pfps_pkg::OP_W-1:0]              op,
	input  logic [pfps_pkg::SLOT_W-1:0]            slot,
	input  logic signed [pfps_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [pfps_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [pfps_pkg::COORD_W-1:0]    goal_x,
	input  logic signed [pfps_pkg::COORD_W-1:0]    goal_y,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pfps_pkg::COORD_W-1:0]    way_x,
	output logic signed [pfps_pkg::COORD_W-1:0]    way_y,
	output logic [pfps_pkg::CNT_W-1:0]             way_index,
	output logic                                   last
);

	pfps_pkg::state_t state_q, state_d;

	logic [pfps_pkg::LEN_W-1:0] step_q;
	logic [pfps_pkg::LEN_W-1:0] unit_q;
	logic [pfps_pkg::GAIN_W-1:0] gain_q;
	logic [pfps_pkg::CNT_W-1:0] limit_q;

	logic signed [pfps_pkg::COORD_W-1:0] obs_x_q [pfps_pkg::NUM_OBSTACLES];
	logic signed [pfps_pkg::COORD_W-1:0] obs_y_q [pfps_pkg::NUM_OBSTACLES];
	logic [pfps_pkg::NUM_OBSTACLES-1:0] obs_valid_q;

	logic signed [pfps_pkg::COORD_W-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [pfps_pkg::CNT_W-1:0] move_count_q;
	logic path_active_q;
	logic is_start_q;
	logic [pfps_pkg::CNT_W-1:0] way_index_q;
	logic last_q;

	logic signed [pfps_pkg::DIFF_W-1:0] gx_q, gy_q, ox_q, oy_q;
	logic [pfps_pkg::DSQ_W-1:0] gsq_q, osq_q;
	logic [pfps_pkg::DIFF_W-1:0] dg_q, od_q;
	logic [pfps_pkg::RT_W-1:0] ml_q;
	logic arrived_q;
	logic fac_neg_q;
	logic [pfps_pkg::DIFF_W:0] r_q;
	logic signed [pfps_pkg::MOV_W-1:0] mx_q, my_q;
	logic [pfps_pkg::OBS_IW-1:0] idx_q;

	logic signed [pfps_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [pfps_pkg::PROD_W-1:0] prod_q, acc_q;

	pfps_pkg::div_req_t div_req;
	logic div_done;
	logic signed [pfps_pkg::QUO_W-1:0] div_quo;
	pfps_pkg::sqrt_req_t sq_req;
	logic sq_done;
	logic [pfps_pkg::RT_W-1:0] sq_root;

	logic in_take;
	logic [pfps_pkg::OBS_IW-1:0] wr_idx;
	logic [pfps_pkg::DIFF_W-1:0] reach;
	logic [pfps_pkg::DIFF_W-1:0] t_val;
	logic [pfps_pkg::SQ_W-1:0] sum_sq;
	logic signed [pfps_pkg::DIFF_W-1:0] new_x, new_y;
	logic [pfps_pkg::CNT_W-1:0] count_next;
	logic last_d;

	assign in_take = in_valid && !in_stall;
	assign in_stall = (state_q != pfps_pkg::ST_IDLE);
	assign out_valid = (state_q == pfps_pkg::ST_OUT);
	assign way_x = cur_x_q;
	assign way_y = cur_y_q;
	assign way_index = way_index_q;
	assign last = last_q;

	assign wr_idx = pfps_pkg::OBS_IW'(slot);
	assign reach = pfps_pkg::DIFF_W'(unit_q) + pfps_pkg::DIFF_W'({unit_q, 1'b0});
	assign t_val = reach - od_q;
	assign sum_sq = pfps_pkg::SQ_W'(acc_q + prod_q);
	assign new_x = pfps_pkg::DIFF_W'(cur_x_q) + pfps_pkg::DIFF_W'(div_quo);
	assign new_y = pfps_pkg::DIFF_W'(cur_y_q) + pfps_pkg::DIFF_W'(div_quo);
	assign count_next = (move_count_q < pfps_pkg::CNT_MAX) ? move_count_q + 1'b1 : move_count_q;
	assign last_d = is_start_q ? arrived_q : (arrived_q || (count_next >= limit_q));

	pfps_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	pfps_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.done   (sq_done),
		.root   (sq_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfps_pkg::ST_IDLE: begin
				if (in_take && (op == pfps_pkg::OP_START || (op == pfps_pkg::OP_STEP && path_active_q))) begin
					state_d = pfps_pkg::ST_G1;
				end
			end
			pfps_pkg::ST_G1: state_d = pfps_pkg::ST_G2;
			pfps_pkg::ST_G2: state_d = pfps_pkg::ST_G3;
			pfps_pkg::ST_G3: state_d = pfps_pkg::ST_G4;
			pfps_pkg::ST_G4: state_d = is_start_q ? pfps_pkg::ST_FIN : pfps_pkg::ST_DG;
			pfps_pkg::ST_DG: begin
				if (sq_done) begin
					state_d = (sq_root == '0) ? pfps_pkg::ST_OCHK : pfps_pkg::ST_A1;
				end
			end
			pfps_pkg::ST_A1: state_d = pfps_pkg::ST_A2;
			pfps_pkg::ST_A2: state_d = pfps_pkg::ST_A3;
			pfps_pkg::ST_A3: if (div_done) state_d = pfps_pkg::ST_A4;
			pfps_pkg::ST_A4: state_d = pfps_pkg::ST_A5;
			pfps_pkg::ST_A5: state_d = pfps_pkg::ST_A6;
			pfps_pkg::ST_A6: if (div_done) state_d = pfps_pkg::ST_OCHK;
			pfps_pkg::ST_OCHK: state_d = obs_valid_q[idx_q] ? pfps_pkg::ST_O1 : pfps_pkg::ST_ONEXT;
			pfps_pkg::ST_O1: state_d = pfps_pkg::ST_O2;
			pfps_pkg::ST_O2: state_d = pfps_pkg::ST_O3;
			pfps_pkg::ST_O3: state_d = pfps_pkg::ST_O4;
			pfps_pkg::ST_O4: begin
				state_d = (osq_q >= pfps_pkg::DSQ_W'(prod_q)) ? pfps_pkg::ST_ONEXT : pfps_pkg::ST_O5;
			end
			pfps_pkg::ST_O5: if (sq_done) state_d = pfps_pkg::ST_O6;
			pfps_pkg::ST_O6: state_d = pfps_pkg::ST_O7;
			pfps_pkg::ST_O7: state_d = pfps_pkg::ST_O8;
			pfps_pkg::ST_O8: state_d = pfps_pkg::ST_O9;
			pfps_pkg::ST_O9: begin
				if (div_done) begin
					if (od_q != '0) begin
						state_d = pfps_pkg::ST_R1;
					end else begin
						state_d = (dg_q == '0) ? pfps_pkg::ST_ONEXT : pfps_pkg::ST_T1;
					end
				end
			end
			pfps_pkg::ST_R1: state_d = pfps_pkg::ST_R2;
			pfps_pkg::ST_R2: state_d = pfps_pkg::ST_R3;
			pfps_pkg::ST_R3: if (div_done) state_d = pfps_pkg::ST_R4;
			pfps_pkg::ST_R4: state_d = pfps_pkg::ST_R5;
			pfps_pkg::ST_R5: state_d = pfps_pkg::ST_R6;
			pfps_pkg::ST_R6: begin
				if (div_done) begin
					state_d = (dg_q == '0) ? pfps_pkg::ST_ONEXT : pfps_pkg::ST_T1;
				end
			end
			pfps_pkg::ST_T1: state_d = pfps_pkg::ST_T2;
			pfps_pkg::ST_T2: state_d = pfps_pkg::ST_T3;
			pfps_pkg::ST_T3: state_d = pfps_pkg::ST_T4;
			pfps_pkg::ST_T4: state_d = pfps_pkg::ST_T5;
			pfps_pkg::ST_T5: if (div_done) state_d = pfps_pkg::ST_T6;
			pfps_pkg::ST_T6: state_d = pfps_pkg::ST_T7;
			pfps_pkg::ST_T7: state_d = pfps_pkg::ST_T8;
			pfps_pkg::ST_T8: if (div_done) state_d = pfps_pkg::ST_ONEXT;
			pfps_pkg::ST_ONEXT: begin
				if (idx_q == pfps_pkg::OBS_IW'(pfps_pkg::NUM_OBSTACLES - 1)) begin
					state_d = pfps_pkg::ST_M1;
				end else begin
					state_d = pfps_pkg::ST_OCHK;
				end
			end
			pfps_pkg::ST_M1: state_d = pfps_pkg::ST_M2;
			pfps_pkg::ST_M2: state_d = pfps_pkg::ST_M3;
			pfps_pkg::ST_M3: state_d = (sum_sq == '0) ? pfps_pkg::ST_FIN : pfps_pkg::ST_M4;
			pfps_pkg::ST_M4: if (sq_done) state_d = pfps_pkg::ST_M5;
			pfps_pkg::ST_M5: state_d = pfps_pkg::ST_M6;
			pfps_pkg::ST_M6: state_d = pfps_pkg::ST_M7;
			pfps_pkg::ST_M7: if (div_done) state_d = pfps_pkg::ST_M8;
			pfps_pkg::ST_M8: state_d = pfps_pkg::ST_M9;
			pfps_pkg::ST_M9: state_d = pfps_pkg::ST_M10;
			pfps_pkg::ST_M10: if (div_done) state_d = pfps_pkg::ST_FIN;
			pfps_pkg::ST_FIN: state_d = pfps_pkg::ST_OUT;
			pfps_pkg::ST_OUT: if (!out_stall) state_d = pfps_pkg::ST_IDLE;
			default: state_d = pfps_pkg::ST_IDLE;
		endcase
	end

	// shared unit operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		sq_req = '0;
		case (state_q)
			pfps_pkg::ST_G1: begin
				mul_a = pfps_pkg::MUL_W'(gx_q);
				mul_b = pfps_pkg::MUL_W'(gx_q);
			end
			pfps_pkg::ST_G2: begin
				mul_a = pfps_pkg::MUL_W'(gy_q);
				mul_b = pfps_pkg::MUL_W'(gy_q);
			end
			pfps_pkg::ST_G3: begin
				mul_a = pfps_pkg::MUL_W'(step_q);
				mul_b = pfps_pkg::MUL_W'(step_q);
			end
			pfps_pkg::ST_G4: begin
				sq_req.start = !is_start_q;
				sq_req.rad = pfps_pkg::SQ_W'(gsq_q);
			end
			pfps_pkg::ST_A1: begin
				mul_a = pfps_pkg::MUL_W'(gx_q);
				mul_b = pfps_pkg::MUL_W'(gain_q);
			end
			pfps_pkg::ST_A4: begin
				mul_a = pfps_pkg::MUL_W'(gy_q);
				mul_b = pfps_pkg::MUL_W'(gain_q);
			end
			pfps_pkg::ST_A2, pfps_pkg::ST_A5: begin
				div_req.start = 1'b1;
				div_req.dvd = pfps_pkg::DVD_W'(prod_q) <<< pfps_pkg::FRAC_SH;
				div_req.dvs = pfps_pkg::DVS_W'(dg_q);
			end
			pfps_pkg::ST_O1: begin
				mul_a = pfps_pkg::MUL_W'(ox_q);
				mul_b = pfps_pkg::MUL_W'(ox_q);
			end
			pfps_pkg::ST_O2: begin
				mul_a = pfps_pkg::MUL_W'(oy_q);
				mul_b = pfps_pkg::MUL_W'(oy_q);
			end
			pfps_pkg::ST_O3: begin
				mul_a = pfps_pkg::MUL_W'(reach);
				mul_b = pfps_pkg::MUL_W'(reach);
			end
			pfps_pkg::ST_O4: begin
				sq_req.start = (osq_q < pfps_pkg::DSQ_W'(prod_q));
				sq_req.rad = pfps_pkg::SQ_W'(osq_q);
			end
			pfps_pkg::ST_O6: begin
				mul_a = pfps_pkg::MUL_W'(t_val);
				mul_b = pfps_pkg::MUL_W'(t_val);
			end
			pfps_pkg::ST_O7: begin
				mul_a = pfps_pkg::MUL_W'(unit_q);
				mul_b = pfps_pkg::MUL_W'(unit_q);
			end
			pfps_pkg::ST_O8: begin
				// falloff: (reach - od)^2 in q.16 over unit^2
				div_req.start = 1'b1;
				div_req.dvd = pfps_pkg::DVD_W'(acc_q) <<< pfps_pkg::FRAC_SH;
				div_req.dvs = pfps_pkg::DVS_W'(prod_q);
			end
			pfps_pkg::ST_R1: begin
				mul_a = pfps_pkg::MUL_W'(ox_q);
				mul_b = pfps_pkg::MUL_W'(r_q);
			end
			pfps_pkg::ST_R4: begin
				mul_a = pfps_pkg::MUL_W'(oy_q);
				mul_b = pfps_pkg::MUL_W'(r_q);
			end
			pfps_pkg::ST_R2, pfps_pkg::ST_R5: begin
				div_req.start = 1'b1;
				div_req.dvd = pfps_pkg::DVD_W'(prod_q);
				div_req.dvs = pfps_pkg::DVS_W'(od_q);
			end
			pfps_pkg::ST_T1: begin
				mul_a = pfps_pkg::MUL_W'(oy_q);
				mul_b = pfps_pkg::MUL_W'(gx_q);
			end
			pfps_pkg::ST_T2: begin
				mul_a = pfps_pkg::MUL_W'(ox_q);
				mul_b = pfps_pkg::MUL_W'(gy_q);
			end
			pfps_pkg::ST_T3: begin
				mul_a = pfps_pkg::MUL_W'(gy_q);
				mul_b = pfps_pkg::MUL_W'(r_q);
			end
			pfps_pkg::ST_T6: begin
				mul_a = pfps_pkg::MUL_W'(gx_q);
				mul_b = pfps_pkg::MUL_W'(r_q);
			end
			pfps_pkg::ST_T4, pfps_pkg::ST_T7: begin
				div_req.start = 1'b1;
				div_req.dvd = pfps_pkg::DVD_W'(prod_q) <<< 1;
				div_req.dvs = pfps_pkg::DVS_W'(dg_q);
			end
			pfps_pkg::ST_M1: begin
				mul_a = pfps_pkg::MUL_W'(mx_q);
				mul_b = pfps_pkg::MUL_W'(mx_q);
			end
			pfps_pkg::ST_M2: begin
				mul_a = pfps_pkg::MUL_W'(my_q);
				mul_b = pfps_pkg::MUL_W'(my_q);
			end
			pfps_pkg::ST_M3: begin
				sq_req.start = (sum_sq != '0);
				sq_req.rad = sum_sq;
			end
			pfps_pkg::ST_M5: begin
				mul_a = pfps_pkg::MUL_W'(mx_q);
				mul_b = pfps_pkg::MUL_W'(step_q);
			end
			pfps_pkg::ST_M8: begin
				mul_a = pfps_pkg::MUL_W'(my_q);
				mul_b = pfps_pkg::MUL_W'(step_q);
			end
			pfps_pkg::ST_M6, pfps_pkg::ST_M9: begin
				div_req.start = 1'b1;
				div_req.dvd = pfps_pkg::DVD_W'(prod_q);
				div_req.dvs = pfps_pkg::DVS_W'(ml_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, a zero acts as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pfps_pkg::STEP_RST;
			unit_q <= pfps_pkg::UNIT_RST;
			gain_q <= pfps_pkg::GAIN_RST;
			limit_q <= pfps_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pfps_pkg::CFG_STEP_LENGTH: begin
					step_q <= (cfg_data == '0) ? pfps_pkg::LEN_W'(1) : cfg_data;
				end
				pfps_pkg::CFG_INFLUENCE_UNIT: begin
					unit_q <= (cfg_data == '0) ? pfps_pkg::LEN_W'(1) : cfg_data;
				end
				pfps_pkg::CFG_ATTRACTION_GAIN: begin
					gain_q <= (cfg_data[pfps_pkg::GAIN_W-1:0] == '0) ?
						pfps_pkg::GAIN_W'(1) : cfg_data[pfps_pkg::GAIN_W-1:0];
				end
				pfps_pkg::CFG_MAX_WAYPOINTS: begin
					limit_q <= (cfg_data[pfps_pkg::CNT_W-1:0] == '0) ?
						pfps_pkg::CNT_W'(1) : cfg_data[pfps_pkg::CNT_W-1:0];
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// path control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_valid_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			move_count_q <= '0;
			path_active_q <= 1'b0;
			is_start_q <= 1'b0;
			way_index_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (state_q == pfps_pkg::ST_IDLE && in_take) begin
				if (op == pfps_pkg::OP_LOAD && 32'(slot) < pfps_pkg::NUM_OBSTACLES) begin
					obs_valid_q[wr_idx] <= 1'b1;
				end
				if (op == pfps_pkg::OP_START) begin
					cur_x_q <= pos_x;
					cur_y_q <= pos_y;
					tgt_x_q <= goal_x;
					tgt_y_q <= goal_y;
					move_count_q <= '0;
					path_active_q <= 1'b1;
					is_start_q <= 1'b1;
				end else begin
					is_start_q <= 1'b0;
				end
			end
			if (state_q == pfps_pkg::ST_M7 && div_done) begin
				cur_x_q <= pfps_pkg::sat_coord(new_x);
			end
			if (state_q == pfps_pkg::ST_M10 && div_done) begin
				cur_y_q <= pfps_pkg::sat_coord(new_y);
			end
			if (state_q == pfps_pkg::ST_FIN) begin
				last_q <= last_d;
				if (last_d) begin
					path_active_q <= 1'b0;
				end
				if (is_start_q) begin
					way_index_q <= '0;
				end else begin
					way_index_q <= count_next;
					move_count_q <= count_next;
				end
			end
		end
	end

	// obstacle table, written only by load transfers
	always_ff @(posedge clk) begin
		if (state_q == pfps_pkg::ST_IDLE && in_take && op == pfps_pkg::OP_LOAD &&
				32'(slot) < pfps_pkg::NUM_OBSTACLES) begin
			obs_x_q[wr_idx] <= pos_x;
			obs_y_q[wr_idx] <= pos_y;
		end
	end

	// working registers of the step computation
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			pfps_pkg::ST_IDLE: begin
				if (op == pfps_pkg::OP_START) begin
					gx_q <= pfps_pkg::DIFF_W'(goal_x) - pfps_pkg::DIFF_W'(pos_x);
					gy_q <= pfps_pkg::DIFF_W'(goal_y) - pfps_pkg::DIFF_W'(pos_y);
				end else begin
					gx_q <= pfps_pkg::DIFF_W'(tgt_x_q) - pfps_pkg::DIFF_W'(cur_x_q);
					gy_q <= pfps_pkg::DIFF_W'(tgt_y_q) - pfps_pkg::DIFF_W'(cur_y_q);
				end
				mx_q <= '0;
				my_q <= '0;
				idx_q <= '0;
				dg_q <= '0;
			end
			pfps_pkg::ST_G2, pfps_pkg::ST_O2, pfps_pkg::ST_O7, pfps_pkg::ST_T2,
			pfps_pkg::ST_M2: begin
				acc_q <= prod_q;
			end
			pfps_pkg::ST_G3: gsq_q <= pfps_pkg::DSQ_W'(acc_q + prod_q);
			pfps_pkg::ST_G4: arrived_q <= (gsq_q <= pfps_pkg::DSQ_W'(prod_q));
			pfps_pkg::ST_DG: if (sq_done) dg_q <= pfps_pkg::DIFF_W'(sq_root);
			pfps_pkg::ST_A3: if (div_done) mx_q <= pfps_pkg::MOV_W'(div_quo);
			pfps_pkg::ST_A6: if (div_done) my_q <= pfps_pkg::MOV_W'(div_quo);
			pfps_pkg::ST_OCHK: begin
				ox_q <= pfps_pkg::DIFF_W'(cur_x_q) - pfps_pkg::DIFF_W'(obs_x_q[idx_q]);
				oy_q <= pfps_pkg::DIFF_W'(cur_y_q) - pfps_pkg::DIFF_W'(obs_y_q[idx_q]);
			end
			pfps_pkg::ST_O3: osq_q <= pfps_pkg::DSQ_W'(acc_q + prod_q);
			pfps_pkg::ST_O5: if (sq_done) od_q <= pfps_pkg::DIFF_W'(sq_root);
			pfps_pkg::ST_O9: if (div_done) r_q <= (pfps_pkg::DIFF_W + 1)'(div_quo);
			pfps_pkg::ST_R3: if (div_done) mx_q <= mx_q + pfps_pkg::MOV_W'(div_quo);
			pfps_pkg::ST_R6: if (div_done) my_q <= my_q + pfps_pkg::MOV_W'(div_quo);
			// swirl direction from the sign of the cross product
			pfps_pkg::ST_T3: fac_neg_q <= (acc_q - prod_q) > 0;
			pfps_pkg::ST_T5: begin
				if (div_done) begin
					mx_q <= fac_neg_q ? mx_q - pfps_pkg::MOV_W'(div_quo) :
						mx_q + pfps_pkg::MOV_W'(div_quo);
				end
			end
			pfps_pkg::ST_T8: begin
				if (div_done) begin
					my_q <= fac_neg_q ? my_q + pfps_pkg::MOV_W'(div_quo) :
						my_q - pfps_pkg::MOV_W'(div_quo);
				end
			end
			pfps_pkg::ST_ONEXT: idx_q <= idx_q + 1'b1;
			pfps_pkg::ST_M4: if (sq_done) ml_q <= sq_root;
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`PFPS_ASSERT_NOW(a_take_only_when_drained, clk, arst_n, in_valid && !in_stall, !out_valid, "item taken while a result is pending")
	`PFPS_ASSERT_NOW(a_last_closes_path, clk, arst_n, out_valid && last, !path_active_q, "path still active after its last waypoint")
	`PFPS_ASSERT_NOW(a_step_index_nonzero, clk, arst_n, out_valid && !is_start_q, way_index != '0, "step waypoint carries index zero")

endmodule
